// ===== sv/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants shared by the nearest palette colour search core:
// request and result words, command codes and field widths.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int COMP_W     = 8;
  localparam int IDX_FIELD_W = 8;
  localparam int DIST_W     = 18;
  localparam int MAN_W      = 10;
  localparam int BRIGHT_W   = 19;

  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic [IDX_FIELD_W-1:0] entry_index;
    logic [COMP_W-1:0]      red;
    logic [COMP_W-1:0]      green;
    logic [COMP_W-1:0]      blue;
  } in_word_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] match_index;
    logic [DIST_W-1:0]      match_distance;
  } out_word_t;

endpackage

// ===== sv/nearest_palette_colour_search_core.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_colour_search_core
// Palette store with nearest colour search over all entries.
//
// A request word is taken at a rising edge where start is high and busy is
// low. A write word (cmd = write) stores {red, green, blue} at entry_index in
// the same cycle, gives no result and leaves busy low, so another word can
// follow at once; an index at or beyond PALETTE_ENTRIES is dropped.
// A query word raises busy and scans the palette memory one entry per
// cycle through its single read port, feeding a three stage compare pipeline
// of memory read, differences and keys. The result word is shown on result
// for one cycle with done high when the last entry leaves the pipeline;
// busy falls in that same cycle, so the next word may be taken while done is
// high.
// Throughput: one write per cycle while busy is low; queries do not overlap.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// Reset clears the per-entry valid flags at once, so every entry reads as
// black until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_palette_colour_search_core
  import nps_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  request,
  output logic      done,
  output out_word_t result
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state;

  logic [3*COMP_W-1:0] mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] valid;

  logic               accept;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;

  logic [COMP_W-1:0]  q_red, q_green, q_blue;
  logic [IDX_W-1:0]   scan_idx;
  logic               scan_last;

  // stage 1: memory read
  logic               s1_live, s1_last;
  logic [IDX_W-1:0]   s1_idx;
  logic [3*COMP_W-1:0] s1_data;
  logic               s1_valid;

  // stage 2: differences
  logic               s2_live, s2_last;
  logic [IDX_W-1:0]   s2_idx;
  logic [COMP_W-1:0]  s2_dr, s2_dg, s2_db;
  logic [COMP_W-1:0]  s2_er, s2_eg, s2_eb;

  // stage 3: keys
  logic               s3_live, s3_last;
  logic [IDX_W-1:0]   s3_idx;
  logic [DIST_W-1:0]  s3_sq;
  logic [MAN_W-1:0]   s3_man;
  logic [BRIGHT_W-1:0] s3_bright;

  // running best
  logic               have;
  logic [IDX_W-1:0]   best_idx;
  logic [DIST_W-1:0]  best_sq;
  logic [MAN_W-1:0]   best_man;
  logic [BRIGHT_W-1:0] best_bright;
  logic               better;

  logic [COMP_W-1:0]  ent_r, ent_g, ent_b;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign wr_en   = accept && (request.cmd == CMD_WRITE)
                   && ({1'b0, request.entry_index} < 9'(PALETTE_ENTRIES));
  assign wr_addr = request.entry_index[IDX_W-1:0];
  assign scan_last = (scan_idx == IDX_W'(PALETTE_ENTRIES - 1));

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // palette memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {request.red, request.green, request.blue};
    end
    s1_data <= mem[scan_idx];
  end

  // valid flags, unwritten entries read as black
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_valid <= valid[scan_idx];
  end

  assign ent_r = s1_valid ? s1_data[3*COMP_W-1:2*COMP_W] : '0;
  assign ent_g = s1_valid ? s1_data[2*COMP_W-1:COMP_W]   : '0;
  assign ent_b = s1_valid ? s1_data[COMP_W-1:0]          : '0;

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && (request.cmd == CMD_QUERY)) begin
      q_red   <= request.red;
      q_green <= request.green;
      q_blue  <= request.blue;
    end
    s1_idx <= scan_idx;

    s2_idx <= s1_idx;
    s2_dr  <= abs_diff(q_red, ent_r);
    s2_dg  <= abs_diff(q_green, ent_g);
    s2_db  <= abs_diff(q_blue, ent_b);
    s2_er  <= ent_r;
    s2_eg  <= ent_g;
    s2_eb  <= ent_b;

    s3_idx    <= s2_idx;
    s3_sq     <= DIST_W'(s2_dr) * DIST_W'(s2_dr) + DIST_W'(s2_dg) * DIST_W'(s2_dg)
                 + DIST_W'(s2_db) * DIST_W'(s2_db);
    s3_man    <= MAN_W'(s2_dr) + MAN_W'(s2_dg) + MAN_W'(s2_db);
    s3_bright <= BRIGHT_W'(s2_eb) * BRIGHT_W'(s2_eb)
                 + ((BRIGHT_W'(s2_eg) * BRIGHT_W'(s2_eg)) << 1)
                 + ((BRIGHT_W'(s2_er) * BRIGHT_W'(s2_er)) << 1);

    if (s3_live && better) begin
      best_idx    <= s3_idx;
      best_sq     <= s3_sq;
      best_man    <= s3_man;
      best_bright <= s3_bright;
    end
  end

  // strict improvement keeps the lowest index on a full tie
  assign better = !have
                  || (s3_sq < best_sq)
                  || ((s3_sq == best_sq) && ((s3_man < best_man)
                  || ((s3_man == best_man) && (s3_bright < best_bright))));

  // control and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
      s1_live  <= 1'b0;
      s1_last  <= 1'b0;
      s2_live  <= 1'b0;
      s2_last  <= 1'b0;
      s3_live  <= 1'b0;
      s3_last  <= 1'b0;
      have     <= 1'b0;
      done     <= 1'b0;
    end else begin
      done    <= 1'b0;
      s1_live <= (state == ST_SCAN);
      s1_last <= (state == ST_SCAN) && scan_last;
      s2_live <= s1_live;
      s2_last <= s1_last;
      s3_live <= s2_live;
      s3_last <= s2_last;
      if (s3_live) begin
        have <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (request.cmd == CMD_QUERY)) begin
            state    <= ST_SCAN;
            scan_idx <= '0;
            have     <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (s3_last) begin
            state <= ST_IDLE;
            done  <= 1'b1;
            result.match_index    <= better ? IDX_FIELD_W'(s3_idx) : IDX_FIELD_W'(best_idx);
            result.match_distance <= better ? s3_sq : best_sq;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_from_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_DRAIN))
    else $error("result word without a finished scan");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.match_distance <= MAX_DIST))
    else $error("match distance out of range");

  a_pipe_while_busy: assert property (@(posedge clk) disable iff (rst)
    (s1_live || s2_live || s3_live) |-> busy)
    else $error("scan pipeline active while idle");

  a_query_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.cmd == CMD_QUERY)) |=> busy)
    else $error("query taken without raising busy");

  a_write_keeps_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.cmd == CMD_WRITE)) |=> !busy)
    else $error("write word raised busy");

endmodule

// ===== sim/nearest_palette_colour_search_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_palette_colour_search_core_test
// Self-checking testbench for the nearest palette colour search core.
// A short table of directed words covers reset state, extreme colours,
// exact matches and each tie break. Random words follow: palette writes
// and queries, many of them copies or near copies of stored entries.
// Each result word is checked against the typed word of its row or a behavioral
// search over a local palette copy. The sender works in bursts with random gaps.
// ----------------------------------------------------------------------------
module nearest_palette_colour_search_core_test;
  import nps_pkg::*;

  localparam int ENTRIES      = 256;
  localparam int RANDOM_ITEMS = 1030;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic TYPED      = 1'b1;
  localparam logic PREDICTED  = 1'b0;

  typedef struct packed {
    logic      typed;
    in_word_t  word;
    out_word_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_word_t  request = '0;
  logic      busy;
  logic      done;
  out_word_t result;

  logic [23:0] palette_model [ENTRIES];
  out_word_t   pending_matches [$];
  row_t        directed_rows [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  nearest_palette_colour_search_core #(
    .PALETTE_ENTRIES(ENTRIES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic out_word_t nearest_entry(input in_word_t q);
    out_word_t best;
    int best_sq, best_man, best_bright;
    int er, eg, eb, dr, dg, db, sq, man, bright;
    logic better;
    best = '0;
    best_sq = 0;
    best_man = 0;
    best_bright = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      er = palette_model[i][23:16];
      eg = palette_model[i][15:8];
      eb = palette_model[i][7:0];
      dr = (int'(q.red) > er) ? int'(q.red) - er : er - int'(q.red);
      dg = (int'(q.green) > eg) ? int'(q.green) - eg : eg - int'(q.green);
      db = (int'(q.blue) > eb) ? int'(q.blue) - eb : eb - int'(q.blue);
      sq = dr * dr + dg * dg + db * db;
      man = dr + dg + db;
      bright = eb * eb + 2 * eg * eg + 2 * er * er;
      if (i == 0) begin
        better = 1'b1;
      end else if (sq != best_sq) begin
        better = sq < best_sq;
      end else if (man != best_man) begin
        better = man < best_man;
      end else begin
        better = bright < best_bright;
      end
      if (better) begin
        best.match_index = i[IDX_FIELD_W-1:0];
        best.match_distance = sq[DIST_W-1:0];
        best_sq = sq;
        best_man = man;
        best_bright = bright;
      end
    end
    return best;
  endfunction

  function automatic row_t mk_row(input logic cmd, input int idx, input int r, input int g,
                                  input int b, input logic typed, input int widx,
                                  input int wdist);
    row_t row;
    row.typed = typed;
    row.word.cmd = cmd;
    row.word.entry_index = idx[IDX_FIELD_W-1:0];
    row.word.red = r[COMP_W-1:0];
    row.word.green = g[COMP_W-1:0];
    row.word.blue = b[COMP_W-1:0];
    row.want.match_index = widx[IDX_FIELD_W-1:0];
    row.want.match_distance = wdist[DIST_W-1:0];
    return row;
  endfunction

  function automatic logic [COMP_W-1:0] nudge(input logic [COMP_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[COMP_W-1:0];
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    logic [23:0] base;
    int pick;
    w = in_word_t'({1'b0, $urandom});
    w.cmd = ($urandom_range(99) < 45) ? CMD_QUERY : CMD_WRITE;
    base = palette_model[$urandom_range(ENTRIES - 1)];
    pick = $urandom_range(9);
    if (pick < 3) begin
      // copy of a stored entry: duplicates and exact matches
      {w.red, w.green, w.blue} = base;
    end else if (pick < 6) begin
      w.red = nudge(base[23:16]);
      w.green = nudge(base[15:8]);
      w.blue = nudge(base[7:0]);
    end else if (pick == 9) begin
      w.red = $urandom_range(1) ? 8'hff : 8'h00;
      w.green = $urandom_range(1) ? 8'hff : 8'h00;
      w.blue = $urandom_range(1) ? 8'hff : 8'h00;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      case ($urandom_range(19))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(1, 280);
        default:       gap = $urandom_range(1, 6);
      endcase
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    // word taken at this edge
    if (w.cmd == CMD_WRITE) begin
      if (w.entry_index < ENTRIES) palette_model[w.entry_index] = {w.red, w.green, w.blue};
    end else begin
      pending_matches.push_back(typed ? want : nearest_entry(w));
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_word;
    if (!rst && done) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result word: match_index %0d, match_distance %0d",
               result.match_index, result.match_distance);
        error_count++;
      end else begin
        exp_word = pending_matches.pop_front();
        if (result.match_index !== exp_word.match_index) begin
          $error("match_index: expected %0d, got %0d", exp_word.match_index,
                 result.match_index);
          error_count++;
        end
        if (result.match_distance !== exp_word.match_distance) begin
          $error("match_distance: expected %0d, got %0d", exp_word.match_distance,
                 result.match_distance);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) palette_model[i] = '0;

    directed_rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 0, TYPED, 0, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 255, 255, 255, 255, TYPED, 0, int'(MAX_DIST)));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 255, TYPED, 0, 65025));
    directed_rows.push_back(mk_row(CMD_WRITE, 255, 255, 255, 255, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 255, 255, 255, TYPED, 255, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 0, TYPED, 0, 0));
    directed_rows.push_back(mk_row(CMD_WRITE, 0, 255, 255, 255, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 0, TYPED, 1, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 255, 255, 255, TYPED, 0, 0));
    // equal squared distance, manhattan decides
    directed_rows.push_back(mk_row(CMD_WRITE, 1, 103, 104, 100, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_WRITE, 2, 105, 100, 100, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 100, 100, 100, PREDICTED, 0, 0));
    // equal squared and manhattan distance, brightness decides
    directed_rows.push_back(mk_row(CMD_WRITE, 3, 202, 50, 200, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_WRITE, 4, 198, 50, 200, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 200, 50, 200, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_WRITE, 5, 62, 60, 60, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_WRITE, 6, 60, 62, 60, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_WRITE, 7, 60, 60, 62, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 60, 60, 60, PREDICTED, 0, 0));
    // full tie, lowest index decides
    directed_rows.push_back(mk_row(CMD_WRITE, 8, 32, 30, 30, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_WRITE, 9, 30, 32, 30, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 30, 30, 30, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_WRITE, 128, 128, 64, 32, PREDICTED, 0, 0));
    directed_rows.push_back(mk_row(CMD_QUERY, 77, 127, 66, 31, PREDICTED, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_word(directed_rows[i].word, directed_rows[i].typed,
                                         directed_rows[i].want);
    repeat (RANDOM_ITEMS) send_word(random_word(), PREDICTED, '0);
    start <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
